// File: sv/gif_frame_compositor_defines.svh
// Assertion macros for the GIF frame compositor.
`ifndef GIF_FRAME_COMPOSITOR_DEFINES_SVH
`define GIF_FRAME_COMPOSITOR_DEFINES_SVH

`ifndef SYNTHESIS
`define GFC_ASSERT(label, expr, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) else $error(msg);
`define GFC_ASSERT_NEXT(label, cond, expr, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |=> (expr)) \
        else $error(msg);
`else
`define GFC_ASSERT(label, expr, msg)
`define GFC_ASSERT_NEXT(label, cond, expr, msg)
`endif

`endif

// File: sv/gfc_pkg.sv
// Shared types and constants of the GIF frame compositor.
package gfc_pkg;

    // Coordinate width wide enough for 0..4096.
    localparam int COORD_W = 13;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;

    // Request op codes.
    localparam logic [2:0] OP_FRAME = 3'd0;
    localparam logic [2:0] OP_PAL   = 3'd1;
    localparam logic [2:0] OP_PIX   = 3'd2;
    localparam logic [2:0] OP_READ  = 3'd3;
    localparam logic [2:0] OP_NEW   = 3'd4;

    localparam logic [2:0] DISP_BACKGROUND = 3'd2;
    localparam logic [2:0] DISP_PREVIOUS   = 3'd3;
    localparam logic [7:0] OPAQUE_ALPHA    = 8'd255;

    // Command kinds passed from front to back.
    localparam logic [2:0] K_FILL    = 3'd0;
    localparam logic [2:0] K_BG      = 3'd1;
    localparam logic [2:0] K_RESTORE = 3'd2;
    localparam logic [2:0] K_SAVE    = 3'd3;
    localparam logic [2:0] K_PIX     = 3'd4;
    localparam logic [2:0] K_PAL     = 3'd5;
    localparam logic [2:0] K_READ    = 3'd6;

    typedef struct packed {
        logic [2:0]         kind;
        logic [COORD_W-1:0] x0;
        logic [COORD_W-1:0] y0;
        logic [COORD_W-1:0] x1;
        logic [COORD_W-1:0] y1;
        logic [7:0]         idx;
        logic [23:0]        rgb;
        logic               outside;
    } cmd_t;

endpackage

// File: sv/gfc_cmd_fifo.sv
// Short command queue between the front and the back of the compositor.
`include "gif_frame_compositor_defines.svh"

module gfc_cmd_fifo
    import gfc_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic empty,
    output cmd_t head
);

    cmd_t               q_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_AW:0]   count_reg;

    assign full  = (count_reg == (FIFO_AW+1)'(FIFO_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = q_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    `GFC_ASSERT(a_no_overflow, !(push && full), "push into full command queue")
    `GFC_ASSERT(a_no_underflow, !(pop && empty), "pop from empty command queue")
    `GFC_ASSERT(a_count_bound, count_reg <= (FIFO_AW+1)'(FIFO_DEPTH), "queue count too large")
    `GFC_ASSERT_NEXT(a_push_fills, push && !pop, !empty, "queue empty after push")

endmodule

// File: sv/gfc_front.sv
// Front end: accepts requests, tracks frame state and emits memory commands.
module gfc_front
    import gfc_pkg::*;
#(
    parameter int MAX_WIDTH     = 256,
    parameter int MAX_HEIGHT    = 256,
    parameter int PALETTE_DEPTH = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [8:0]  cfg_width,
    input  logic [8:0]  cfg_height,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_op,
    input  logic [15:0] s_pos_x,
    input  logic [15:0] s_pos_y,
    input  logic [15:0] s_frame_width,
    input  logic [15:0] s_frame_height,
    input  logic [2:0]  s_disposal,
    input  logic        s_transparent_en,
    input  logic [7:0]  s_color_index,
    input  logic [8:0]  s_color_count,
    input  logic [23:0] s_color_rgb,
    input  logic        fifo_full,
    output logic        push,
    output cmd_t        push_cmd
);

    localparam logic [COORD_W-1:0] MAXW = COORD_W'(MAX_WIDTH);
    localparam logic [COORD_W-1:0] MAXH = COORD_W'(MAX_HEIGHT);
    localparam logic [8:0]         PDEP = 9'(PALETTE_DEPTH);

    logic [15:0] cur_left_reg, cur_top_reg, cur_w_reg, cur_h_reg;
    logic [15:0] cur_left_next, cur_top_next, cur_w_next, cur_h_next;
    logic [15:0] last_left_reg, last_top_reg, last_w_reg, last_h_reg;
    logic [15:0] last_left_next, last_top_next, last_w_next, last_h_next;
    logic [2:0]  last_disp_reg, last_disp_next;
    logic        trans_en_reg, trans_en_next;
    logic [7:0]  trans_idx_reg, trans_idx_next;
    logic [8:0]  pal_count_reg, pal_count_next;
    logic [15:0] col_reg, col_next, row_reg, row_next;
    logic        done_reg, done_next;
    logic        pend_valid_reg, pend_valid_next;
    cmd_t        pend_cmd_reg, pend_cmd_next;

    logic [COORD_W-1:0] act_w, act_h;
    logic               accept;
    logic [16:0]        cx, cy;
    cmd_t               disp_cmd, save_cmd;
    logic               disp_go;

    function automatic cmd_t clip_rect(input logic [15:0] l, input logic [15:0] t,
                                       input logic [15:0] w, input logic [15:0] h,
                                       input logic [COORD_W-1:0] aw,
                                       input logic [COORD_W-1:0] ah);
        logic [16:0] xe, ye, xc, yc;
        cmd_t        c;
        c  = '0;
        xe = {1'b0, l} + {1'b0, w};
        ye = {1'b0, t} + {1'b0, h};
        xc = (xe < 17'(aw)) ? xe : 17'(aw);
        yc = (ye < 17'(ah)) ? ye : 17'(ah);
        c.outside = ({1'b0, l} >= xc) || ({1'b0, t} >= yc);
        c.x0 = l[COORD_W-1:0];
        c.y0 = t[COORD_W-1:0];
        c.x1 = xc[COORD_W-1:0];
        c.y1 = yc[COORD_W-1:0];
        return c;
    endfunction

    assign act_w   = (COORD_W'(cfg_width) > MAXW) ? MAXW : COORD_W'(cfg_width);
    assign act_h   = (COORD_W'(cfg_height) > MAXH) ? MAXH : COORD_W'(cfg_height);
    assign s_ready = !pend_valid_reg && !fifo_full;
    assign accept  = s_valid && s_ready;
    assign cx      = {1'b0, cur_left_reg} + {1'b0, col_reg};
    assign cy      = {1'b0, cur_top_reg} + {1'b0, row_reg};

    always_comb begin
        disp_cmd = clip_rect(last_left_reg, last_top_reg, last_w_reg, last_h_reg,
                             act_w, act_h);
        disp_cmd.kind = (last_disp_reg == DISP_PREVIOUS) ? K_RESTORE : K_BG;
        disp_go = !disp_cmd.outside &&
                  (last_disp_reg == DISP_BACKGROUND || last_disp_reg == DISP_PREVIOUS);
        save_cmd = clip_rect(s_pos_x, s_pos_y, s_frame_width, s_frame_height, act_w, act_h);
        save_cmd.kind = K_SAVE;
    end

    always_comb begin
        cur_left_next   = cur_left_reg;
        cur_top_next    = cur_top_reg;
        cur_w_next      = cur_w_reg;
        cur_h_next      = cur_h_reg;
        last_left_next  = last_left_reg;
        last_top_next   = last_top_reg;
        last_w_next     = last_w_reg;
        last_h_next     = last_h_reg;
        last_disp_next  = last_disp_reg;
        trans_en_next   = trans_en_reg;
        trans_idx_next  = trans_idx_reg;
        pal_count_next  = pal_count_reg;
        col_next        = col_reg;
        row_next        = row_reg;
        done_next       = done_reg;
        pend_valid_next = pend_valid_reg;
        pend_cmd_next   = pend_cmd_reg;
        push            = 1'b0;
        push_cmd        = '0;

        // drain the second half of a frame start first
        if (pend_valid_reg && !fifo_full) begin
            push            = 1'b1;
            push_cmd        = pend_cmd_reg;
            pend_valid_next = 1'b0;
        end

        if (accept) begin
            unique case (s_op)
                OP_FRAME: begin
                    if (disp_go) begin
                        push     = 1'b1;
                        push_cmd = disp_cmd;
                        if (s_disposal == DISP_PREVIOUS && !save_cmd.outside) begin
                            pend_valid_next = 1'b1;
                            pend_cmd_next   = save_cmd;
                        end
                    end else if (s_disposal == DISP_PREVIOUS && !save_cmd.outside) begin
                        push     = 1'b1;
                        push_cmd = save_cmd;
                    end
                    cur_left_next  = s_pos_x;
                    cur_top_next   = s_pos_y;
                    cur_w_next     = s_frame_width;
                    cur_h_next     = s_frame_height;
                    last_left_next = s_pos_x;
                    last_top_next  = s_pos_y;
                    last_w_next    = s_frame_width;
                    last_h_next    = s_frame_height;
                    last_disp_next = s_disposal;
                    trans_en_next  = s_transparent_en;
                    trans_idx_next = s_color_index;
                    pal_count_next = (s_color_count > PDEP) ? PDEP : s_color_count;
                    col_next       = '0;
                    row_next       = '0;
                    done_next      = (s_frame_width == '0) || (s_frame_height == '0);
                end
                OP_PAL: begin
                    if ({1'b0, s_color_index} < PDEP) begin
                        push         = 1'b1;
                        push_cmd     = '0;
                        push_cmd.kind = K_PAL;
                        push_cmd.idx = s_color_index;
                        push_cmd.rgb = s_color_rgb;
                    end
                end
                OP_PIX: begin
                    if (!done_reg) begin
                        if (cx < 17'(act_w) && cy < 17'(act_h) &&
                            !(trans_en_reg && s_color_index == trans_idx_reg) &&
                            {1'b0, s_color_index} < pal_count_reg) begin
                            push          = 1'b1;
                            push_cmd      = '0;
                            push_cmd.kind = K_PIX;
                            push_cmd.x0   = cx[COORD_W-1:0];
                            push_cmd.y0   = cy[COORD_W-1:0];
                            push_cmd.idx  = s_color_index;
                        end
                        // advance in row-major order
                        if (col_reg == cur_w_reg - 16'd1) begin
                            col_next = '0;
                            row_next = row_reg + 16'd1;
                            if (row_reg + 16'd1 == cur_h_reg) begin
                                done_next = 1'b1;
                            end
                        end else begin
                            col_next = col_reg + 16'd1;
                        end
                    end
                end
                OP_READ: begin
                    push          = 1'b1;
                    push_cmd      = '0;
                    push_cmd.kind = K_READ;
                    push_cmd.outside = ({1'b0, s_pos_x} >= 17'(act_w)) ||
                                       ({1'b0, s_pos_y} >= 17'(act_h));
                    push_cmd.x0   = s_pos_x[COORD_W-1:0];
                    push_cmd.y0   = s_pos_y[COORD_W-1:0];
                end
                OP_NEW: begin
                    // fill only the active canvas; an empty canvas needs no fill
                    if (act_w != '0 && act_h != '0) begin
                        push          = 1'b1;
                        push_cmd      = '0;
                        push_cmd.kind = K_FILL;
                        push_cmd.x1   = act_w;
                        push_cmd.y1   = act_h;
                    end
                    cur_left_next  = '0;
                    cur_top_next   = '0;
                    cur_w_next     = '0;
                    cur_h_next     = '0;
                    last_left_next = '0;
                    last_top_next  = '0;
                    last_w_next    = '0;
                    last_h_next    = '0;
                    last_disp_next = '0;
                    trans_en_next  = 1'b0;
                    trans_idx_next = '0;
                    col_next       = '0;
                    row_next       = '0;
                    done_next      = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_left_reg   <= '0;
            cur_top_reg    <= '0;
            cur_w_reg      <= '0;
            cur_h_reg      <= '0;
            last_left_reg  <= '0;
            last_top_reg   <= '0;
            last_w_reg     <= '0;
            last_h_reg     <= '0;
            last_disp_reg  <= '0;
            trans_en_reg   <= 1'b0;
            trans_idx_reg  <= '0;
            pal_count_reg  <= '0;
            col_reg        <= '0;
            row_reg        <= '0;
            done_reg       <= 1'b1;
            pend_valid_reg <= 1'b0;
        end else begin
            cur_left_reg   <= cur_left_next;
            cur_top_reg    <= cur_top_next;
            cur_w_reg      <= cur_w_next;
            cur_h_reg      <= cur_h_next;
            last_left_reg  <= last_left_next;
            last_top_reg   <= last_top_next;
            last_w_reg     <= last_w_next;
            last_h_reg     <= last_h_next;
            last_disp_reg  <= last_disp_next;
            trans_en_reg   <= trans_en_next;
            trans_idx_reg  <= trans_idx_next;
            pal_count_reg  <= pal_count_next;
            col_reg        <= col_next;
            row_reg        <= row_next;
            done_reg       <= done_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pend_cmd_reg <= pend_cmd_next;
    end

endmodule

// File: sv/gfc_back.sv
// Back end: runs commands against the canvas, restore and palette memories.
module gfc_back
    import gfc_pkg::*;
#(
    parameter int MAX_WIDTH     = 256,
    parameter int MAX_HEIGHT    = 256,
    parameter int PALETTE_DEPTH = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [31:0] bg_argb,
    input  logic        fifo_empty,
    input  cmd_t        head,
    output logic        pop,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_pixel_argb,
    output logic        m_outside_canvas
);

    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int YW    = $clog2(MAX_HEIGHT);
    localparam int AW    = XW + YW;
    localparam int PW    = $clog2(PALETTE_DEPTH);
    localparam int DEPTH = 1 << AW;

    logic [31:0] canvas_mem  [DEPTH];
    logic [31:0] restore_mem [DEPTH];
    logic [23:0] pal_mem     [PALETTE_DEPTH];

    logic [31:0] canvas_rd_reg, restore_rd_reg;
    logic [23:0] pal_rd_reg;

    logic               sweeping_reg;
    logic [COORD_W-1:0] sx_reg, sy_reg;
    logic               b_valid_reg, b_outside_reg;
    logic [2:0]         b_kind_reg;
    logic [AW-1:0]      b_addr_reg;
    logic               m_valid_reg, m_outside_reg;
    logic [31:0]        m_pixel_reg;

    logic               is_sweep, last_x, last_elem, reads_canvas, reads_restore;
    logic               b_wr_canvas, b_wr_restore, hazard, adv, issue;
    logic [COORD_W-1:0] cur_x, cur_y;
    logic [AW-1:0]      addr;
    logic [31:0]        canvas_wdata;

    assign is_sweep = (head.kind == K_FILL) || (head.kind == K_BG) ||
                      (head.kind == K_RESTORE) || (head.kind == K_SAVE);
    assign cur_x     = sweeping_reg ? sx_reg : head.x0;
    assign cur_y     = sweeping_reg ? sy_reg : head.y0;
    assign last_x    = (cur_x + 1'b1 == head.x1);
    assign last_elem = last_x && (cur_y + 1'b1 == head.y1);
    assign addr      = {cur_y[YW-1:0], cur_x[XW-1:0]};

    assign reads_canvas  = (head.kind == K_SAVE) || (head.kind == K_READ && !head.outside);
    assign reads_restore = (head.kind == K_RESTORE);
    assign b_wr_canvas   = b_valid_reg && ((b_kind_reg == K_FILL) || (b_kind_reg == K_BG) ||
                           (b_kind_reg == K_RESTORE) || (b_kind_reg == K_PIX));
    assign b_wr_restore  = b_valid_reg && (b_kind_reg == K_SAVE);

    // hold a read behind a write of the same memory still in flight
    assign hazard = (reads_canvas && b_wr_canvas) || (reads_restore && b_wr_restore);
    // hold the pipe while a read result waits for the output register
    assign adv    = !(b_valid_reg && b_kind_reg == K_READ && m_valid_reg && !m_ready);
    assign issue  = !fifo_empty && adv && !hazard;
    assign pop    = issue && (!is_sweep || last_elem);

    always_comb begin
        case (b_kind_reg)
            K_RESTORE: canvas_wdata = restore_rd_reg;
            K_PIX:     canvas_wdata = {OPAQUE_ALPHA, pal_rd_reg};
            default:   canvas_wdata = bg_argb;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (issue && reads_canvas) begin
            canvas_rd_reg <= canvas_mem[addr];
        end
        if (adv && b_wr_canvas) begin
            canvas_mem[b_addr_reg] <= canvas_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (issue && reads_restore) begin
            restore_rd_reg <= restore_mem[addr];
        end
        if (adv && b_wr_restore) begin
            restore_mem[b_addr_reg] <= canvas_rd_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (issue && head.kind == K_PIX) begin
            pal_rd_reg <= pal_mem[head.idx[PW-1:0]];
        end
        if (issue && head.kind == K_PAL) begin
            pal_mem[head.idx[PW-1:0]] <= head.rgb;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sweeping_reg <= 1'b0;
            b_valid_reg  <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (issue && is_sweep) begin
                sweeping_reg <= !last_elem;
            end
            if (adv) begin
                b_valid_reg <= issue;
            end
            if (adv && b_valid_reg && b_kind_reg == K_READ) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (issue && is_sweep) begin
            if (last_x) begin
                sx_reg <= head.x0;
                sy_reg <= cur_y + 1'b1;
            end else begin
                sx_reg <= cur_x + 1'b1;
                sy_reg <= cur_y;
            end
        end
        if (adv) begin
            b_kind_reg    <= head.kind;
            b_addr_reg    <= addr;
            b_outside_reg <= head.outside;
        end
        if (adv && b_valid_reg && b_kind_reg == K_READ) begin
            m_pixel_reg   <= b_outside_reg ? 32'd0 : canvas_rd_reg;
            m_outside_reg <= b_outside_reg;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_pixel_argb     = m_pixel_reg;
    assign m_outside_canvas = m_outside_reg;

endmodule

// File: sv/gif_frame_compositor.sv
// Top level of the GIF frame compositor: config registers, front, queue and back.
//
// The compositor keeps an ARGB canvas of MAX_WIDTH x MAX_HEIGHT pixels in on-chip
// memory, next to a restore copy of the same size and a palette of PALETTE_DEPTH
// colors. Requests enter on the s_ channel: frame start, palette write, pixel index,
// canvas read and new animation. A front stage accepts each request, keeps the frame
// setup and the row-major pixel position, clips against the active canvas and turns
// the request into at most one memory command (a frame start that both disposes the
// previous rectangle and saves its own gives two, and holds s_ready low until the
// second is queued). A four-entry command queue decouples it from the back stage,
// which owns the memory ports and handles one pixel per cycle while no hazard or
// waiting read result holds it. Pixel indices stream at one per cycle while the
// queue has room. A disposal or save sweep visits each clipped pixel of its rectangle
// in turn, and a new animation fills the active canvas (nothing when it is empty);
// while a sweep runs the queue fills and s_ready drops. A command that reads a memory
// right behind a write of that memory still in the back pipe waits until it is done.
// With the queue empty, a canvas read passes the back-stage register and then the
// output register, where m_valid rises and the result is held until taken.
// Configuration is written through cfg_we/cfg_index/cfg_wdata and must only change
// while the block is idle. The canvas holds no defined value until the first new
// animation request has been issued.
module gif_frame_compositor
    import gfc_pkg::*;
#(
    parameter int MAX_WIDTH     = 256,
    parameter int MAX_HEIGHT    = 256,
    parameter int PALETTE_DEPTH = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_op,
    input  logic [15:0] s_pos_x,
    input  logic [15:0] s_pos_y,
    input  logic [15:0] s_frame_width,
    input  logic [15:0] s_frame_height,
    input  logic [2:0]  s_disposal,
    input  logic        s_transparent_en,
    input  logic [7:0]  s_color_index,
    input  logic [8:0]  s_color_count,
    input  logic [23:0] s_color_rgb,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_pixel_argb,
    output logic        m_outside_canvas
);

    // Register indexes of the configuration port.
    localparam logic [1:0] CFG_CANVAS_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_CANVAS_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_BACKGROUND    = 2'd2;

    logic [8:0]  canvas_width_reg, canvas_height_reg;
    logic [31:0] background_reg;

    logic fifo_push, fifo_pop, fifo_full, fifo_empty;
    cmd_t fifo_in, fifo_head;

    // Config writes; an index past the list is dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            canvas_width_reg  <= 9'd256;
            canvas_height_reg <= 9'd256;
            background_reg    <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_CANVAS_WIDTH:  canvas_width_reg  <= cfg_wdata[8:0];
                CFG_CANVAS_HEIGHT: canvas_height_reg <= cfg_wdata[8:0];
                CFG_BACKGROUND:    background_reg    <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Front: accept each request and classify it into a memory command.
    gfc_front #(
        .MAX_WIDTH     (MAX_WIDTH),
        .MAX_HEIGHT    (MAX_HEIGHT),
        .PALETTE_DEPTH (PALETTE_DEPTH)
    ) u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_width        (canvas_width_reg),
        .cfg_height       (canvas_height_reg),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_op             (s_op),
        .s_pos_x          (s_pos_x),
        .s_pos_y          (s_pos_y),
        .s_frame_width    (s_frame_width),
        .s_frame_height   (s_frame_height),
        .s_disposal       (s_disposal),
        .s_transparent_en (s_transparent_en),
        .s_color_index    (s_color_index),
        .s_color_count    (s_color_count),
        .s_color_rgb      (s_color_rgb),
        .fifo_full        (fifo_full),
        .push             (fifo_push),
        .push_cmd         (fifo_in)
    );

    // Queue: let front and back stall on their own.
    gfc_cmd_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (fifo_push),
        .push_cmd (fifo_in),
        .full     (fifo_full),
        .pop      (fifo_pop),
        .empty    (fifo_empty),
        .head     (fifo_head)
    );

    // Back: run sweeps, pixel writes and reads on the memories.
    gfc_back #(
        .MAX_WIDTH     (MAX_WIDTH),
        .MAX_HEIGHT    (MAX_HEIGHT),
        .PALETTE_DEPTH (PALETTE_DEPTH)
    ) u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .bg_argb          (background_reg),
        .fifo_empty       (fifo_empty),
        .head             (fifo_head),
        .pop              (fifo_pop),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_pixel_argb     (m_pixel_argb),
        .m_outside_canvas (m_outside_canvas)
    );

endmodule

// File: sim/gif_frame_compositor_test.sv
// Self-checking testbench for the GIF frame compositor: predicted canvas reads.
module gif_frame_compositor_test
    import gfc_pkg::*;
();

    // Register indexes on the configuration write port.
    localparam logic [1:0] REG_CANVAS_WIDTH  = 2'd0;
    localparam logic [1:0] REG_CANVAS_HEIGHT = 2'd1;
    localparam logic [1:0] REG_BACKGROUND    = 2'd2;

    localparam int CANVAS_MAX   = 256;
    localparam int PAL_DEPTH    = 256;
    localparam int STALL_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 20;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [31:0] cfg_wdata = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [2:0]  s_op = '0;
    logic [15:0] s_pos_x = '0;
    logic [15:0] s_pos_y = '0;
    logic [15:0] s_frame_width = '0;
    logic [15:0] s_frame_height = '0;
    logic [2:0]  s_disposal = '0;
    logic        s_transparent_en = 1'b0;
    logic [7:0]  s_color_index = '0;
    logic [8:0]  s_color_count = '0;
    logic [23:0] s_color_rgb = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_pixel_argb;
    logic        m_outside_canvas;

    gif_frame_compositor dut (.*);

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    typedef struct {
        logic [2:0]  op;
        logic [15:0] pos_x;
        logic [15:0] pos_y;
        logic [15:0] frame_width;
        logic [15:0] frame_height;
        logic [2:0]  disposal;
        logic        transparent_en;
        logic [7:0]  color_index;
        logic [8:0]  color_count;
        logic [23:0] color_rgb;
    } request_t;

    typedef struct {
        logic [31:0] argb;
        logic        outside;
    } pixel_read_t;

    // Mirror of the block's state.
    logic [31:0] canvas_mirror [CANVAS_MAX*CANVAS_MAX];
    logic [31:0] restore_mirror [CANVAS_MAX*CANVAS_MAX];
    logic [23:0] palette_mirror [PAL_DEPTH];
    logic [8:0]  width_reg = 9'd256;
    logic [8:0]  height_reg = 9'd256;
    logic [31:0] background_reg = '0;
    int unsigned palette_count;
    int unsigned prev_left, prev_top, prev_w, prev_h;
    logic [2:0]  prev_disposal;
    int unsigned frame_left, frame_top, frame_w, frame_h;
    logic        frame_trans_en;
    logic [7:0]  frame_trans_idx;
    int unsigned pixel_count;

    pixel_read_t pending_reads[$];

    int sender_gap_pct = 0;
    int receiver_stall_pct = 0;
    int hold_cycles = 0;
    int mismatch_count = 0;
    int idle_cycles = 0;

    function automatic int unsigned active_w();
        return (width_reg > CANVAS_MAX) ? CANVAS_MAX : width_reg;
    endfunction

    function automatic int unsigned active_h();
        return (height_reg > CANVAS_MAX) ? CANVAS_MAX : height_reg;
    endfunction

    // mode 0 fills background, 1 restores saved pixels, 2 saves pixels
    function automatic void sweep_rect(int unsigned l, int unsigned t, int unsigned w,
                                       int unsigned h, int mode);
        int unsigned x1, y1, a;
        x1 = l + w;
        y1 = t + h;
        if (x1 > active_w()) x1 = active_w();
        if (y1 > active_h()) y1 = active_h();
        for (int unsigned y = t; y < y1; y++) begin
            for (int unsigned x = l; x < x1; x++) begin
                a = y * CANVAS_MAX + x;
                case (mode)
                    0: canvas_mirror[a] = background_reg;
                    1: canvas_mirror[a] = restore_mirror[a];
                    default: restore_mirror[a] = canvas_mirror[a];
                endcase
            end
        end
    endfunction

    function automatic void clear_frame_state();
        prev_left = 0; prev_top = 0; prev_w = 0; prev_h = 0;
        prev_disposal = '0;
        frame_left = 0; frame_top = 0; frame_w = 0; frame_h = 0;
        frame_trans_en = 1'b0;
        frame_trans_idx = '0;
        pixel_count = 0;
    endfunction

    // Advance the mirror by one accepted request and queue any read result.
    function automatic void composite_request(request_t r);
        int unsigned cx, cy;
        pixel_read_t res;
        case (r.op)
            OP_FRAME: begin
                if (prev_disposal == DISP_BACKGROUND)
                    sweep_rect(prev_left, prev_top, prev_w, prev_h, 0);
                else if (prev_disposal == DISP_PREVIOUS)
                    sweep_rect(prev_left, prev_top, prev_w, prev_h, 1);
                frame_left = 32'(r.pos_x);
                frame_top = 32'(r.pos_y);
                frame_w = 32'(r.frame_width);
                frame_h = 32'(r.frame_height);
                if (r.disposal == DISP_PREVIOUS)
                    sweep_rect(frame_left, frame_top, frame_w, frame_h, 2);
                prev_left = frame_left; prev_top = frame_top;
                prev_w = frame_w; prev_h = frame_h;
                prev_disposal = r.disposal;
                frame_trans_en = r.transparent_en;
                frame_trans_idx = r.color_index;
                palette_count = (r.color_count > PAL_DEPTH) ? PAL_DEPTH : 32'(r.color_count);
                pixel_count = 0;
            end
            OP_PAL: begin
                if (r.color_index < PAL_DEPTH) palette_mirror[r.color_index] = r.color_rgb;
            end
            OP_PIX: begin
                if (frame_w != 0 && pixel_count < frame_w * frame_h) begin
                    cx = frame_left + pixel_count % frame_w;
                    cy = frame_top + pixel_count / frame_w;
                    pixel_count++;
                    if (cx < active_w() && cy < active_h()
                        && !(frame_trans_en && r.color_index == frame_trans_idx)
                        && r.color_index < palette_count)
                        canvas_mirror[cy * CANVAS_MAX + cx] =
                            {OPAQUE_ALPHA, palette_mirror[r.color_index]};
                end
            end
            OP_READ: begin
                if (r.pos_x >= active_w() || r.pos_y >= active_h()) begin
                    res.argb = '0;
                    res.outside = 1'b1;
                end else begin
                    res.argb = canvas_mirror[r.pos_y * CANVAS_MAX + r.pos_x];
                    res.outside = 1'b0;
                end
                pending_reads.insert(pending_reads.size(), res);
            end
            OP_NEW: begin
                sweep_rect(0, 0, CANVAS_MAX, CANVAS_MAX, 0);
                clear_frame_state();
            end
            default: ;
        endcase
    endfunction

    // Offer one request; random content in the fields the op ignores.
    task automatic send_request(request_t r);
        @(negedge aclk);
        while ($urandom_range(99) < sender_gap_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_op <= r.op;
        s_pos_x <= r.pos_x;
        s_pos_y <= r.pos_y;
        s_frame_width <= r.frame_width;
        s_frame_height <= r.frame_height;
        s_disposal <= r.disposal;
        s_transparent_en <= r.transparent_en;
        s_color_index <= r.color_index;
        s_color_count <= r.color_count;
        s_color_rgb <= r.color_rgb;
        do @(posedge aclk); while (!s_ready);
        composite_request(r);
    endtask

    function automatic request_t noise_request(logic [2:0] op);
        request_t r;
        r.op = op;
        r.pos_x = 16'($urandom);
        r.pos_y = 16'($urandom);
        r.frame_width = 16'($urandom);
        r.frame_height = 16'($urandom);
        r.disposal = 3'($urandom);
        r.transparent_en = 1'($urandom);
        r.color_index = 8'($urandom);
        r.color_count = 9'($urandom);
        r.color_rgb = 24'($urandom);
        return r;
    endfunction

    task automatic send_frame(int x, int y, int w, int h, logic [2:0] disp, logic ten,
                              logic [7:0] tidx, logic [8:0] cnt);
        request_t r;
        r = noise_request(OP_FRAME);
        r.pos_x = 16'(x); r.pos_y = 16'(y); r.frame_width = 16'(w); r.frame_height = 16'(h);
        r.disposal = disp; r.transparent_en = ten;
        r.color_index = tidx; r.color_count = cnt;
        send_request(r);
    endtask

    task automatic send_op_index(logic [2:0] op, logic [7:0] idx);
        request_t r;
        r = noise_request(op);
        r.color_index = idx;
        send_request(r);
    endtask

    task automatic send_read(int x, int y);
        request_t r;
        r = noise_request(OP_READ);
        r.pos_x = 16'(x);
        r.pos_y = 16'(y);
        send_request(r);
    endtask

    // Drain: a read queues behind every sweep, so its return means the block is idle.
    // The coordinate is always off the canvas, so no stored pixel is touched.
    task automatic wait_idle();
        send_read(65535, 65535);
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_reads.size() != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] data);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        case (idx)
            REG_CANVAS_WIDTH:  width_reg = data[8:0];
            REG_CANVAS_HEIGHT: height_reg = data[8:0];
            REG_BACKGROUND:    background_reg = data;
            default: ;
        endcase
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    // Reconfigure while idle and refill so that every active pixel is defined.
    task automatic start_animation(logic [8:0] w, logic [8:0] h, logic [31:0] bg);
        wait_idle();
        write_reg(REG_CANVAS_WIDTH, 32'(w));
        write_reg(REG_CANVAS_HEIGHT, 32'(h));
        write_reg(REG_BACKGROUND, bg);
        send_op_index(OP_NEW, 8'($urandom));
    endtask

    task automatic load_palette();
        request_t r;
        for (int i = 0; i < PAL_DEPTH; i++) begin
            r = noise_request(OP_PAL);
            r.color_index = 8'(i);
            send_request(r);
        end
    endtask

    task automatic test_directed_ops();
        send_read(0, 0);
        send_read(255, 255);
        send_read(256, 0);
        send_read(65535, 65535);
        // count above the palette depth saturates; index 5 is transparent
        send_frame(0, 0, 2, 2, DISP_BACKGROUND, 1'b1, 8'd5, 9'd511);
        send_op_index(OP_PIX, 8'd5);
        send_op_index(OP_PIX, 8'd255);
        send_op_index(OP_PIX, 8'd0);
        send_op_index(OP_PIX, 8'd1);
        send_op_index(OP_PIX, 8'd2);    // excess pixel, ignored
        send_read(0, 0);
        send_read(1, 0);
        // disposal-previous frame, index above the palette count is skipped
        send_frame(1, 1, 2, 1, DISP_PREVIOUS, 1'b0, 8'd0, 9'd3);
        send_op_index(OP_PIX, 8'd2);
        send_op_index(OP_PIX, 8'd200);
        send_read(1, 1);
        // restores the saved pixels, then a frame entirely off the canvas
        send_frame(65535, 65535, 65535, 65535, 3'd7, 1'b1, 8'd255, 9'd0);
        send_op_index(OP_PIX, 8'd0);
        send_read(1, 1);
        send_read(0, 0);
        send_op_index(3'd5, 8'd0);
        send_op_index(3'd6, 8'd0);
        send_op_index(3'd7, 8'd0);
        // oversized rectangle clipped at the corner, zero-width frame after it
        send_frame(250, 250, 65535, 65535, DISP_BACKGROUND, 1'b0, 8'd0, 9'd256);
        send_frame(0, 0, 0, 7, 3'd1, 1'b0, 8'd0, 9'd256);
        send_op_index(OP_PIX, 8'd3);
        send_read(255, 255);
    endtask

    task automatic test_zero_canvas();
        start_animation(9'd0, 9'd0, 32'h1234_5678);
        send_frame(0, 0, 3, 3, DISP_PREVIOUS, 1'b0, 8'd0, 9'd256);
        repeat (9) send_op_index(OP_PIX, 8'($urandom));
        send_frame(0, 0, 3, 3, DISP_BACKGROUND, 1'b0, 8'd0, 9'd256);
        send_read(0, 0);
        send_read($urandom_range(65535), $urandom_range(65535));
    endtask

    task automatic test_single_pixel_canvas();
        start_animation(9'd1, 9'd1, 32'hFFFF_FFFF);
        send_read(0, 0);
        send_read(1, 0);
        send_read(0, 1);
        send_frame(0, 0, 2, 2, DISP_PREVIOUS, 1'b0, 8'd0, 9'd256);
        repeat (4) send_op_index(OP_PIX, 8'($urandom));
        send_read(0, 0);
        send_frame(0, 0, 1, 1, DISP_BACKGROUND, 1'b0, 8'd0, 9'd256);
        send_read(0, 0);
    endtask

    // One well-formed frame with random content, then a few reads; rarely noise.
    task automatic random_frame(ref int sent);
        int unsigned w, h, x, y, npix;
        logic [8:0] cnt;
        logic [7:0] tidx, idx;
        if ($urandom_range(9) == 0) begin
            send_request(noise_request(($urandom_range(7) == 4) ? OP_PAL : 3'($urandom)));
            sent++;
            return;
        end
        w = $urandom_range(6);
        h = $urandom_range(5);
        x = $urandom_range(active_w() + 2);
        y = $urandom_range(active_h() + 2);
        cnt = ($urandom_range(3) == 0) ? 9'($urandom) : 9'($urandom_range(12));
        tidx = 8'($urandom_range(10));
        if ($urandom_range(15) == 0)
            send_frame($urandom, $urandom, $urandom, $urandom, 3'($urandom), 1'($urandom),
                       8'($urandom), cnt);
        else
            send_frame(x, y, w, h, 3'($urandom), 1'($urandom), tidx, cnt);
        sent++;
        repeat ($urandom_range(2)) begin
            send_op_index(OP_PAL, 8'($urandom_range(12)));
            sent++;
        end
        npix = w * h + $urandom_range(1);
        repeat (npix) begin
            idx = ($urandom_range(7) == 0) ? 8'($urandom) : 8'($urandom_range(14));
            if ($urandom_range(5) == 0) idx = tidx;
            send_op_index(OP_PIX, idx);
            sent++;
        end
        repeat ($urandom_range(1, 3)) begin
            if ($urandom_range(7) == 0)
                send_read($urandom, $urandom);
            else
                send_read(x + $urandom_range(w), y + $urandom_range(h));
            sent++;
        end
    endtask

    task automatic test_random_frames(int target);
        int sent;
        sent = 0;
        while (sent < target) random_frame(sent);
    endtask

    // Hold the receiver off while reads keep coming, so the input stalls.
    task automatic test_backpressure();
        wait_idle();
        hold_cycles = 400;
        repeat (30) send_read($urandom_range(active_w() + 1), $urandom_range(active_h()));
        wait_idle();
    endtask

    // Receiver: stall at random, or hold for a counted stretch when asked.
    always @(negedge aclk) begin
        if (hold_cycles > 0) begin
            m_ready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end else begin
            m_ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    // Compare each returned pixel with the oldest prediction.
    always @(posedge aclk) begin
        pixel_read_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_reads.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected read result argb=%h outside=%b",
                             m_pixel_argb, m_outside_canvas);
            end else begin
                want = pending_reads.pop_front();
                if (m_pixel_argb !== want.argb || m_outside_canvas !== want.outside) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("read mismatch: expected argb=%h outside=%b, got %h %b",
                                 want.argb, want.outside, m_pixel_argb, m_outside_canvas);
                end
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        clear_frame_state();
        palette_count = 0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // full-size canvas, sender idles a quarter of the time, receiver mostly stalls
        sender_gap_pct = 25;
        receiver_stall_pct = 71;
        start_animation(9'd256, 9'd256, 32'h8040_2010);
        load_palette();
        test_directed_ops();
        test_random_frames(35);
        test_zero_canvas();
        test_single_pixel_canvas();

        // oversize registers saturate at the maximum
        sender_gap_pct = 71;
        receiver_stall_pct = 25;
        start_animation(9'd511, 9'd300, 32'h5A5A_A5A5);
        test_random_frames(35);
        test_backpressure();

        // small odd canvas, no idling
        sender_gap_pct = 0;
        receiver_stall_pct = 0;
        start_animation(9'd17, 9'd5, 32'h0000_0000);
        test_random_frames(35);

        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_reads.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
